>>> hw/rtl/ppm_pkg.sv
// Package for the pedal plausibility monitor: widths, word types and the control store.
package ppm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CAL_W     = 12;
    localparam int LEVEL_W   = 10;
    localparam int OUT_W     = 10;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 12;

    localparam int FULL_SCALE_DEF        = 1000;
    localparam int DISCONNECT_CUTOFF_DEF = 100;
    localparam int TIMEOUT_MS_DEF        = 100;

    localparam int PEDAL_SET_LEVEL   = 250;
    localparam int PEDAL_CLEAR_LEVEL = 50;

    localparam logic [CAL_W-1:0]   CAL_MIN_RST     = 12'd0;
    localparam logic [CAL_W-1:0]   CAL_MAX_RST     = 12'd4095;
    localparam logic [LEVEL_W-1:0] DIFF_LIMIT_RST  = 10'd100;
    localparam logic [LEVEL_W-1:0] BRAKE_ACT_RST   = 10'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL0_MIN       = 3'd0,
        REG_ACCEL0_MAX       = 3'd1,
        REG_ACCEL1_MIN       = 3'd2,
        REG_ACCEL1_MAX       = 3'd3,
        REG_BRAKE_MIN        = 3'd4,
        REG_BRAKE_MAX        = 3'd5,
        REG_APPS_DIFF_LIMIT  = 3'd6,
        REG_BRAKE_ACTIVATION = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] accel0_sample;
        logic [SAMPLE_W-1:0] accel1_sample;
        logic [SAMPLE_W-1:0] brake_sample;
        logic [TIME_W-1:0]   now_ms;
    } in_word_t;

    typedef struct packed {
        logic [OUT_W-1:0] accel0_mapped;
        logic [OUT_W-1:0] accel1_mapped;
        logic [OUT_W-1:0] brake_mapped;
        logic             apps_fault_now;
        logic             bse_fault_now;
        logic             apps_disable;
        logic             bse_disable;
        logic             pedal_disable;
    } out_word_t;

    typedef struct packed {
        logic              timing;
        logic [TIME_W-1:0] start_ms;
        logic              disabled;
    } fault_track_t;

    // Datapath operation of one step.
    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_PREP,
        OP_INIT,
        OP_DIV,
        OP_STORE,
        OP_EVAL,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        SEL_ACCEL0,
        SEL_ACCEL1,
        SEL_BRAKE
    } sel_t;

    typedef enum logic [2:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_NO_INPUT,
        JMP_DIV_BUSY,
        JMP_OUT_BUSY
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_ENTRY = 4'd1;

    typedef struct packed {
        op_t   op;
        sel_t  sel;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Control store: map three readings through the shared divider, then evaluate.
    function automatic ucode_t ucode_rom(step_t addr);
        ucode_t w;
        unique case (addr)
            4'd0:    w = '{OP_ACCEPT, SEL_ACCEL0, JMP_NO_INPUT, STEP_IDLE};
            4'd1:    w = '{OP_PREP,   SEL_ACCEL0, JMP_NEVER,    STEP_IDLE};
            4'd2:    w = '{OP_INIT,   SEL_ACCEL0, JMP_NEVER,    STEP_IDLE};
            4'd3:    w = '{OP_DIV,    SEL_ACCEL0, JMP_DIV_BUSY, 4'd3};
            4'd4:    w = '{OP_STORE,  SEL_ACCEL0, JMP_NEVER,    STEP_IDLE};
            4'd5:    w = '{OP_PREP,   SEL_ACCEL1, JMP_NEVER,    STEP_IDLE};
            4'd6:    w = '{OP_INIT,   SEL_ACCEL1, JMP_NEVER,    STEP_IDLE};
            4'd7:    w = '{OP_DIV,    SEL_ACCEL1, JMP_DIV_BUSY, 4'd7};
            4'd8:    w = '{OP_STORE,  SEL_ACCEL1, JMP_NEVER,    STEP_IDLE};
            4'd9:    w = '{OP_PREP,   SEL_BRAKE,  JMP_NEVER,    STEP_IDLE};
            4'd10:   w = '{OP_INIT,   SEL_BRAKE,  JMP_NEVER,    STEP_IDLE};
            4'd11:   w = '{OP_DIV,    SEL_BRAKE,  JMP_DIV_BUSY, 4'd11};
            4'd12:   w = '{OP_STORE,  SEL_BRAKE,  JMP_NEVER,    STEP_IDLE};
            4'd13:   w = '{OP_EVAL,   SEL_ACCEL0, JMP_OUT_BUSY, 4'd13};
            4'd14:   w = '{OP_NOP,    SEL_ACCEL0, JMP_ALWAYS,   STEP_IDLE};
            default: w = '{OP_NOP,    SEL_ACCEL0, JMP_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/pedal_plausibility_monitor.sv
// Pedal plausibility monitor: microcoded sequencer with a shared serial divider.
//
// Usage:
//   in channel  (in_valid, in_stall, in_data): one evaluation word per period, with two
//   accelerator samples, one brake sample and a millisecond timestamp. A word is taken at a
//   clock edge with in_valid high and in_stall low.
//   out channel (out_valid, out_stall, out_data): one result word per input word, with the
//   three mapped levels, the fault flags and the three disable flags.
//   cfg port (cfg_write, cfg_index, cfg_data): calibration registers 0..7, written at a clock
//   edge with cfg_write high; write only while no evaluation is in flight.
// Flow: the result word is registered out of the evaluate step, after the restoring divider
//   has mapped each reading one quotient bit per cycle. One word is in flight at a time; the
//   next word is taken once the sequencer is back at its accept step, even while the previous
//   result still sits in the output register.
// Reset: clears the sequencer, the output valid, the fault timers and all disable flags;
//   calibration registers return to their defaults.
// Stall: a held result keeps its word; the sequencer waits in its evaluate step until the
//   output register is free, so no result is dropped or overwritten; the next result and the
//   next accept wait for as long as the stall lasts.
module pedal_plausibility_monitor
    import ppm_pkg::*;
#(
    parameter int FULL_SCALE        = FULL_SCALE_DEF,
    parameter int DISCONNECT_CUTOFF = DISCONNECT_CUTOFF_DEF,
    parameter int TIMEOUT_MS        = TIMEOUT_MS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Width of a mapped level; the quotient always fits since it never exceeds FULL_SCALE.
    localparam int MAP_W = $clog2(FULL_SCALE + 1);
    localparam int CNT_W = $clog2(MAP_W);
    localparam int NUM_W = CAL_W + MAP_W;
    localparam int CMP_W = (MAP_W > LEVEL_W) ? MAP_W : LEVEL_W;

    localparam logic [MAP_W-1:0]    FS_MAP   = MAP_W'(FULL_SCALE);
    localparam logic [SAMPLE_W-1:0] CUTOFF   = SAMPLE_W'(DISCONNECT_CUTOFF);
    localparam logic [TIME_W-1:0]   TIMEOUT  = TIME_W'(TIMEOUT_MS);
    localparam logic [CMP_W-1:0]    SET_LVL  = CMP_W'(PEDAL_SET_LEVEL);
    localparam logic [CMP_W-1:0]    CLR_LVL  = CMP_W'(PEDAL_CLEAR_LEVEL);

    // Calibration registers.
    logic [CAL_W-1:0]   accel0_min_reg, accel0_max_reg;
    logic [CAL_W-1:0]   accel1_min_reg, accel1_max_reg;
    logic [CAL_W-1:0]   brake_min_reg,  brake_max_reg;
    logic [LEVEL_W-1:0] diff_limit_reg, brake_act_reg;

    // Sequencer.
    step_t  step_reg, step_next;
    ucode_t uc;
    logic   jump;
    logic   in_take;
    logic   out_busy;

    // Datapath.
    in_word_t          in_reg;
    logic [NUM_W-1:0]  num_reg,   num_next;
    logic [CAL_W-1:0]  den_reg,   den_next;
    logic              zspan_reg, zspan_next;
    logic [CAL_W-1:0]  rem_reg,   rem_next;
    logic [MAP_W-1:0]  quo_reg,   quo_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [MAP_W-1:0]  m0_reg,    m0_next;
    logic [MAP_W-1:0]  m1_reg,    m1_next;
    logic [MAP_W-1:0]  mb_reg,    mb_next;

    fault_track_t apps_reg, apps_next;
    fault_track_t bse_reg,  bse_next;
    logic         pedal_reg, pedal_next;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg,       out_next;

    // Operand select and divider signals.
    logic [SAMPLE_W-1:0] smp;
    logic [CAL_W-1:0]    lo, hi, clamped, offs;
    logic [CAL_W:0]      trial;
    logic                q_bit;
    logic [MAP_W-1:0]    mapped;

    // Evaluation signals.
    logic [MAP_W-1:0] diff;
    logic             apps_fault, bse_fault, pedal_set;

    function automatic fault_track_t track(fault_track_t cur, logic fault,
                                           logic [TIME_W-1:0] now);
        fault_track_t nxt;
        logic [TIME_W-1:0] start;
        start = cur.timing ? cur.start_ms : now;
        if (fault)
        begin
            nxt.timing   = 1'b1;
            nxt.start_ms = start;
            nxt.disabled = cur.disabled || ((now - start) > TIMEOUT);
        end
        else
        begin
            nxt = '0;
        end
        return nxt;
    endfunction

    // Configuration writes; bits above a register's width drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel0_min_reg <= CAL_MIN_RST;
            accel0_max_reg <= CAL_MAX_RST;
            accel1_min_reg <= CAL_MIN_RST;
            accel1_max_reg <= CAL_MAX_RST;
            brake_min_reg  <= CAL_MIN_RST;
            brake_max_reg  <= CAL_MAX_RST;
            diff_limit_reg <= DIFF_LIMIT_RST;
            brake_act_reg  <= BRAKE_ACT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACCEL0_MIN:       accel0_min_reg <= cfg_data;
                REG_ACCEL0_MAX:       accel0_max_reg <= cfg_data;
                REG_ACCEL1_MIN:       accel1_min_reg <= cfg_data;
                REG_ACCEL1_MAX:       accel1_max_reg <= cfg_data;
                REG_BRAKE_MIN:        brake_min_reg  <= cfg_data;
                REG_BRAKE_MAX:        brake_max_reg  <= cfg_data;
                REG_APPS_DIFF_LIMIT:  diff_limit_reg <= cfg_data[LEVEL_W-1:0];
                REG_BRAKE_ACTIVATION: brake_act_reg  <= cfg_data[LEVEL_W-1:0];
                default:              ;
            endcase
        end
    end

    // Control word of the current step and the branch decision.
    assign uc       = ucode_rom(step_reg);
    assign out_busy = out_valid_reg && out_stall;
    assign in_stall = (uc.op != OP_ACCEPT);
    assign in_take  = in_valid && (uc.op == OP_ACCEPT);

    always_comb
    begin
        unique case (uc.cond)
            JMP_NEVER:    jump = 1'b0;
            JMP_ALWAYS:   jump = 1'b1;
            JMP_NO_INPUT: jump = !in_valid;
            JMP_DIV_BUSY: jump = (cnt_reg != '0);
            JMP_OUT_BUSY: jump = out_busy;
            default:      jump = 1'b1;
        endcase
        step_next = jump ? uc.target : step_t'(step_reg + 1'b1);
    end

    // Operand select for the reading named by the control word.
    always_comb
    begin
        unique case (uc.sel)
            SEL_ACCEL0:
            begin
                smp = in_reg.accel0_sample;
                lo  = accel0_min_reg;
                hi  = accel0_max_reg;
            end
            SEL_ACCEL1:
            begin
                smp = in_reg.accel1_sample;
                lo  = accel1_min_reg;
                hi  = accel1_max_reg;
            end
            SEL_BRAKE:
            begin
                smp = in_reg.brake_sample;
                lo  = brake_min_reg;
                hi  = brake_max_reg;
            end
            default:
            begin
                smp = in_reg.accel0_sample;
                lo  = accel0_min_reg;
                hi  = accel0_max_reg;
            end
        endcase
        if (smp < lo)
            clamped = lo;
        else if (smp > hi)
            clamped = hi;
        else
            clamped = smp;
        offs = clamped - lo;
    end

    // One restoring step: shift in the next numerator bit, subtract if it fits.
    assign trial  = {rem_reg, quo_reg[MAP_W-1]};
    assign q_bit  = (trial >= {1'b0, den_reg});
    assign mapped = zspan_reg ? '0 : quo_reg;

    // Evaluation terms.
    assign diff       = (m0_reg > m1_reg) ? (m0_reg - m1_reg) : (m1_reg - m0_reg);
    assign apps_fault = (in_reg.accel0_sample < CUTOFF) || (in_reg.accel1_sample < CUTOFF)
                        || (CMP_W'(diff) > CMP_W'(diff_limit_reg));
    assign bse_fault  = (in_reg.brake_sample < CUTOFF);
    assign pedal_set  = (CMP_W'(mb_reg) > CMP_W'(brake_act_reg)) && (CMP_W'(m0_reg) > SET_LVL);

    always_comb
    begin
        num_next       = num_reg;
        den_next       = den_reg;
        zspan_next     = zspan_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        m0_next        = m0_reg;
        m1_next        = m1_reg;
        mb_next        = mb_reg;
        apps_next      = apps_reg;
        bse_next       = bse_reg;
        pedal_next     = pedal_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (uc.op)
            OP_ACCEPT, OP_NOP:
            begin
            end
            OP_PREP:
            begin
                // Scale the offset by full scale; the quotient comes next.
                num_next   = NUM_W'(offs) * NUM_W'(FS_MAP);
                den_next   = hi - lo;
                zspan_next = (hi <= lo);
            end
            OP_INIT:
            begin
                // Upper numerator bits are already below the divisor.
                rem_next = num_reg[NUM_W-1:MAP_W];
                quo_next = num_reg[MAP_W-1:0];
                cnt_next = CNT_W'(MAP_W - 1);
            end
            OP_DIV:
            begin
                rem_next = q_bit ? CAL_W'(trial - {1'b0, den_reg}) : trial[CAL_W-1:0];
                quo_next = {quo_reg[MAP_W-2:0], q_bit};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_STORE:
            begin
                unique case (uc.sel)
                    SEL_ACCEL0: m0_next = mapped;
                    SEL_ACCEL1: m1_next = FS_MAP - mapped;
                    SEL_BRAKE:  mb_next = mapped;
                    default:    ;
                endcase
            end
            OP_EVAL:
            begin
                if (!out_busy)
                begin
                    apps_next  = track(apps_reg, apps_fault, in_reg.now_ms);
                    bse_next   = track(bse_reg, bse_fault, in_reg.now_ms);
                    // Clear test follows set test, so clear wins in the same step.
                    pedal_next = pedal_reg || pedal_set;
                    if ((CMP_W'(m0_reg) < CLR_LVL) || (CMP_W'(m1_reg) < CLR_LVL))
                        pedal_next = 1'b0;

                    out_next.accel0_mapped  = OUT_W'(m0_reg);
                    out_next.accel1_mapped  = OUT_W'(m1_reg);
                    out_next.brake_mapped   = OUT_W'(mb_reg);
                    out_next.apps_fault_now = apps_fault;
                    out_next.bse_fault_now  = bse_fault;
                    out_next.apps_disable   = apps_next.disabled;
                    out_next.bse_disable    = bse_next.disabled;
                    out_next.pedal_disable  = pedal_next;
                    out_valid_next          = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            cnt_reg       <= '0;
            apps_reg      <= '0;
            bse_reg       <= '0;
            pedal_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            apps_reg      <= apps_next;
            bse_reg       <= bse_next;
            pedal_reg     <= pedal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= in_data;
        num_reg   <= num_next;
        den_reg   <= den_next;
        zspan_reg <= zspan_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        m0_reg    <= m0_next;
        m1_reg    <= m1_next;
        mb_reg    <= mb_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // An accepted word starts the mapping program on the next cycle.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (step_reg == STEP_ENTRY))
        else $error("sequencer did not enter the program after accept");

    // Every divide runs the full quotient width.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.op == OP_INIT) |=> (cnt_reg == CNT_W'(MAP_W - 1)))
        else $error("divider count not loaded");

    // A result appears only out of the evaluate step.
    a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(uc.op == OP_EVAL))
        else $error("result raised outside evaluate step");

    // An APPS or BSE disable flag never stands without its fault.
    a_disable_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!out_reg.apps_disable || out_reg.apps_fault_now)
                           && (!out_reg.bse_disable || out_reg.bse_fault_now)))
        else $error("disable flag without fault");

endmodule

>>> sim/ppm_checker.sv
// Checker for the pedal plausibility monitor: follows the calibration, predicts and compares.
`timescale 1ns / 1ps

module ppm_checker
    import ppm_pkg::*;
#(
    parameter int FULL_SCALE        = FULL_SCALE_DEF,
    parameter int DISCONNECT_CUTOFF = DISCONNECT_CUTOFF_DEF,
    parameter int TIMEOUT_MS        = TIMEOUT_MS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_word_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_word_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   pending
);

    logic [CAL_W-1:0]   a0_lo, a0_hi, a1_lo, a1_hi, br_lo, br_hi;
    logic [LEVEL_W-1:0] diff_limit, brake_act;
    fault_track_t       apps_trk, bse_trk;
    logic               pedal_off;
    out_word_t          queued_evals [$];
    int                 taken, delivered;
    int                 fail_cnt = 0;

    assign pending    = taken - delivered;
    assign mismatches = fail_cnt;

    // Clamp to the calibrated span and scale to 0..FULL_SCALE; an empty span maps to 0.
    function automatic int unsigned map_level(logic [SAMPLE_W-1:0] x, logic [CAL_W-1:0] lo,
                                              logic [CAL_W-1:0] hi);
        longint unsigned num;
        logic [CAL_W-1:0] c;
        if (hi <= lo)
            return 0;
        c = (x < lo) ? lo : ((x > hi) ? hi : x);
        num = c - lo;
        num = num * FULL_SCALE;
        return int'(num / (hi - lo));
    endfunction

    task automatic advance_timer(input logic fault, input logic [TIME_W-1:0] now,
                                 inout fault_track_t trk);
        logic [TIME_W-1:0] elapsed;
        if (fault)
        begin
            if (!trk.timing)
            begin
                trk.timing   = 1'b1;
                trk.start_ms = now;
            end
            elapsed = now - trk.start_ms;
            if (elapsed > TIMEOUT_MS)
                trk.disabled = 1'b1;
        end
        else
            trk = '0;
    endtask

    task automatic evaluate_pedals(input in_word_t w, output out_word_t r);
        int unsigned m0, m1, mb, diff;
        logic        apps_fault, bse_fault;
        m0 = map_level(w.accel0_sample, a0_lo, a0_hi);
        m1 = FULL_SCALE - map_level(w.accel1_sample, a1_lo, a1_hi);
        mb = map_level(w.brake_sample, br_lo, br_hi);
        diff = (m0 > m1) ? (m0 - m1) : (m1 - m0);
        apps_fault = (w.accel0_sample < DISCONNECT_CUTOFF) ||
                     (w.accel1_sample < DISCONNECT_CUTOFF) || (diff > diff_limit);
        bse_fault  = w.brake_sample < DISCONNECT_CUTOFF;
        advance_timer(apps_fault, w.now_ms, apps_trk);
        advance_timer(bse_fault, w.now_ms, bse_trk);
        // set first, clear second: a step that does both ends cleared
        if (mb > brake_act && m0 > PEDAL_SET_LEVEL)
            pedal_off = 1'b1;
        if (pedal_off && (m0 < PEDAL_CLEAR_LEVEL || m1 < PEDAL_CLEAR_LEVEL))
            pedal_off = 1'b0;
        r.accel0_mapped  = m0[OUT_W-1:0];
        r.accel1_mapped  = m1[OUT_W-1:0];
        r.brake_mapped   = mb[OUT_W-1:0];
        r.apps_fault_now = apps_fault;
        r.bse_fault_now  = bse_fault;
        r.apps_disable   = apps_trk.disabled;
        r.bse_disable    = bse_trk.disabled;
        r.pedal_disable  = pedal_off;
    endtask

    function automatic string show(out_word_t r);
        return $sformatf("a0 %0d a1 %0d br %0d faults %b%b disables %b%b%b",
                         r.accel0_mapped, r.accel1_mapped, r.brake_mapped,
                         r.apps_fault_now, r.bse_fault_now,
                         r.apps_disable, r.bse_disable, r.pedal_disable);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want, got;
        if (!rst_n)
        begin
            a0_lo      = CAL_MIN_RST;
            a0_hi      = CAL_MAX_RST;
            a1_lo      = CAL_MIN_RST;
            a1_hi      = CAL_MAX_RST;
            br_lo      = CAL_MIN_RST;
            br_hi      = CAL_MAX_RST;
            diff_limit = DIFF_LIMIT_RST;
            brake_act  = BRAKE_ACT_RST;
            apps_trk   = '0;
            bse_trk    = '0;
            pedal_off  = 1'b0;
            queued_evals.delete();
            taken     <= 0;
            delivered <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ACCEL0_MIN:       a0_lo      = cfg_data[CAL_W-1:0];
                    REG_ACCEL0_MAX:       a0_hi      = cfg_data[CAL_W-1:0];
                    REG_ACCEL1_MIN:       a1_lo      = cfg_data[CAL_W-1:0];
                    REG_ACCEL1_MAX:       a1_hi      = cfg_data[CAL_W-1:0];
                    REG_BRAKE_MIN:        br_lo      = cfg_data[CAL_W-1:0];
                    REG_BRAKE_MAX:        br_hi      = cfg_data[CAL_W-1:0];
                    REG_APPS_DIFF_LIMIT:  diff_limit = cfg_data[LEVEL_W-1:0];
                    REG_BRAKE_ACTIVATION: brake_act  = cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                delivered <= delivered + 1;
                got = out_data;
                if (queued_evals.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("[%0t] result with nothing queued: %s", $time, show(got));
                end
                else
                begin
                    want = queued_evals.pop_front();
                    if (got.accel0_mapped !== want.accel0_mapped ||
                        got.accel1_mapped !== want.accel1_mapped ||
                        got.brake_mapped !== want.brake_mapped ||
                        got.apps_fault_now !== want.apps_fault_now ||
                        got.bse_fault_now !== want.bse_fault_now ||
                        got.apps_disable !== want.apps_disable ||
                        got.bse_disable !== want.bse_disable ||
                        got.pedal_disable !== want.pedal_disable)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("[%0t] mismatch: expected %s, got %s",
                                     $time, show(want), show(got));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                taken <= taken + 1;
                evaluate_pedals(in_data, want);
                queued_evals.push_back(want);
            end
        end
    end

endmodule

>>> sim/pedal_plausibility_monitor_tb.sv
// Testbench top for the pedal plausibility monitor: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module pedal_plausibility_monitor_tb;
    import ppm_pkg::*;

    localparam int RUN_LIMIT = 400000;   // cycles before the hard stop
    localparam int LONG_HOLD = 600;      // receiver hold-off that fills the block

    typedef enum int {
        EP_CLEAN,
        EP_SKEW,
        EP_OPEN_ACCEL,
        EP_OPEN_BRAKE,
        EP_NOISE
    } episode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_data;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   mismatches;
    int                   pending;
    int                   cycles = 0;

    // Calibration as last written, used only to shape plausible readings.
    logic [CAL_W-1:0]  cur_a0_lo, cur_a0_hi, cur_a1_lo, cur_a1_hi, cur_br_lo, cur_br_hi;

    // Generator state for the random part.
    int                throttle;
    int                brake_lvl;
    bit                brake_on;
    int                episode_left;
    episode_t          episode_kind;
    logic [TIME_W-1:0] clock_ms;

    bit                burst;          // sender offers back to back
    bit                out_calm;       // receiver takes every word at once
    bit                long_hold_req;  // ask the receiver for one long hold-off

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pedal_plausibility_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ppm_checker pedal_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("[pedal_plausibility_monitor] ERROR");
            $finish;
        end
    end

    // Offer one evaluation word after a random gap and hold it until taken.
    // Leave valid high on return so a gapless next word keeps it up.
    task automatic offer(input in_word_t w);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic offer_raw(input logic [SAMPLE_W-1:0] a0, input logic [SAMPLE_W-1:0] a1,
                             input logic [SAMPLE_W-1:0] br, input logic [TIME_W-1:0] now);
        in_word_t w;
        w.accel0_sample = a0;
        w.accel1_sample = a1;
        w.brake_sample  = br;
        w.now_ms        = now;
        offer(w);
    endtask

    // Drop valid and wait until every evaluation has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write the whole register set back to back; call only with the block idle.
    task automatic load_cal(input logic [CFG_W-1:0] a0lo, input logic [CFG_W-1:0] a0hi,
                            input logic [CFG_W-1:0] a1lo, input logic [CFG_W-1:0] a1hi,
                            input logic [CFG_W-1:0] brlo, input logic [CFG_W-1:0] brhi,
                            input logic [CFG_W-1:0] diff, input logic [CFG_W-1:0] act);
        put_reg(REG_ACCEL0_MIN, a0lo);
        put_reg(REG_ACCEL0_MAX, a0hi);
        put_reg(REG_ACCEL1_MIN, a1lo);
        put_reg(REG_ACCEL1_MAX, a1hi);
        put_reg(REG_BRAKE_MIN, brlo);
        put_reg(REG_BRAKE_MAX, brhi);
        put_reg(REG_APPS_DIFF_LIMIT, diff);
        put_reg(REG_BRAKE_ACTIVATION, act);
        cfg_write <= 1'b0;
        @(posedge clk);
        cur_a0_lo = a0lo;
        cur_a0_hi = a0hi;
        cur_a1_lo = a1lo;
        cur_a1_hi = a1hi;
        cur_br_lo = brlo;
        cur_br_hi = brhi;
    endtask

    // Raw reading that maps close to the given level; anything goes on an empty span.
    function automatic logic [SAMPLE_W-1:0] raw_for(int level, logic [CAL_W-1:0] lo,
                                                    logic [CAL_W-1:0] hi);
        int v;
        if (hi <= lo)
            return SAMPLE_W'($urandom);
        v = int'(lo) + (level * (int'(hi) - int'(lo))) / FULL_SCALE_DEF
            + int'($urandom_range(0, 2));
        if (v > 4095)
            v = 4095;
        return SAMPLE_W'(v);
    endfunction

    // Next word of the random part: mostly a drifting, consistent pedal pair with
    // fault episodes that can run past the timeout, plus some raw noise.
    task automatic next_word(output in_word_t w);
        int r;
        if (episode_left == 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                episode_kind = EP_CLEAN;
            else if (r == 5)
                episode_kind = EP_SKEW;
            else if (r == 6)
                episode_kind = EP_OPEN_ACCEL;
            else if (r == 7)
                episode_kind = EP_OPEN_BRAKE;
            else
                episode_kind = EP_NOISE;
            episode_left = $urandom_range(1, 15);
        end
        episode_left--;

        // advance time a little per step, now and then jump anywhere
        if ($urandom_range(0, 24) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 25);

        throttle = throttle + int'($urandom_range(0, 300)) - 150;
        if (throttle < 0)
            throttle = 0;
        if (throttle > FULL_SCALE_DEF)
            throttle = FULL_SCALE_DEF;
        if ($urandom_range(0, 9) == 0)
            brake_on = !brake_on;
        brake_lvl = brake_on ? int'($urandom_range(150, 1000)) : int'($urandom_range(0, 60));

        w.accel0_sample = raw_for(throttle, cur_a0_lo, cur_a0_hi);
        w.accel1_sample = raw_for(FULL_SCALE_DEF - throttle, cur_a1_lo, cur_a1_hi);
        w.brake_sample  = raw_for(brake_lvl, cur_br_lo, cur_br_hi);
        w.now_ms        = clock_ms;

        case (episode_kind)
            EP_SKEW:
                w.accel1_sample = SAMPLE_W'($urandom);
            EP_OPEN_ACCEL:
                if ($urandom_range(0, 1) == 0)
                    w.accel0_sample = SAMPLE_W'($urandom_range(0, 99));
                else
                    w.accel1_sample = SAMPLE_W'($urandom_range(0, 99));
            EP_OPEN_BRAKE:
                w.brake_sample = SAMPLE_W'($urandom_range(0, 99));
            EP_NOISE:
            begin
                w.accel0_sample = SAMPLE_W'($urandom);
                w.accel1_sample = SAMPLE_W'($urandom);
                w.brake_sample  = SAMPLE_W'($urandom);
            end
            default: ;
        endcase
    endtask

    // One calibration phase of random words; with pressure, start with a long
    // receiver hold-off while the sender keeps offering back to back.
    task automatic run_phase(input int count, input bit pressure);
        in_word_t w;
        for (int k = 0; k < count; k++)
        begin
            if (k % 40 == 0)
                burst = (pressure && k == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
            if (pressure && k == 0)
                long_hold_req = 1'b1;
            next_word(w);
            offer(w);
        end
        settle();
    endtask

    // Receiver: stall a random number of cycles before each result word.
    initial
    begin : sink
        int hold;
        int served;
        served = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (served % 40 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
            hold = out_calm ? 0 : $urandom_range(0, 19);
            if (long_hold_req)
            begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            repeat (hold)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            served++;
        end
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_ACCEL0_MIN;
        cfg_data      <= '0;
        burst         = 1'b0;
        out_calm      = 1'b0;
        long_hold_req = 1'b0;
        cur_a0_lo     = CAL_MIN_RST;
        cur_a0_hi     = CAL_MAX_RST;
        cur_a1_lo     = CAL_MIN_RST;
        cur_a1_hi     = CAL_MAX_RST;
        cur_br_lo     = CAL_MIN_RST;
        cur_br_hi     = CAL_MAX_RST;
        throttle      = 0;
        brake_lvl     = 0;
        brake_on      = 1'b0;
        episode_left  = 0;
        episode_kind  = EP_CLEAN;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset calibration (full spans, limit 100, activation 100).
        // All readings open, timed across the timestamp wrap: 63 ms, exactly 100, then 101.
        offer_raw(12'd0, 12'd0, 12'd0, 32'hFFFF_FFC0);
        offer_raw(12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF);
        offer_raw(12'd0, 12'd0, 12'd0, 32'h0000_0024);
        offer_raw(12'd0, 12'd0, 12'd0, 32'h0000_0025);
        // Clean pair clears both timers; brake and throttle together set pedal disable.
        offer_raw(12'd2048, 12'd2048, 12'd2048, 32'h0000_0030);
        // Difference exactly at the limit, then one past it.
        offer_raw(12'd2048, 12'd2457, 12'd2048, 32'h0000_0032);
        offer_raw(12'd2048, 12'd2462, 12'd2048, 32'h0000_0034);
        // Set and clear of pedal disable in one step: the clear wins.
        offer_raw(12'd4095, 12'd4095, 12'd4095, 32'h0000_0036);
        // Cutoff edges: just below and exactly at.
        offer_raw(12'd99, 12'd2048, 12'd100, 32'h0000_0038);
        offer_raw(12'd100, 12'd4095, 12'd99, 32'h0000_003A);
        offer_raw(12'd4095, 12'd0, 12'd4095, 32'h0000_003C);
        // Throttle level exactly at the set level, brake just under and at activation.
        offer_raw(12'd1024, 12'd3071, 12'd409, 32'h0000_003E);
        offer_raw(12'd1025, 12'd3070, 12'd410, 32'h0000_0040);
        // Throttle below the clear level.
        offer_raw(12'd200, 12'd3900, 12'd4095, 32'h0000_0042);
        // Alternating bit patterns and large time jumps.
        offer_raw(12'hAAA, 12'h555, 12'hAAA, 32'hAAAA_AAAA);
        offer_raw(12'h555, 12'hAAA, 12'h555, 32'h5555_5555);
        offer_raw(12'hFFF, 12'hFFF, 12'h000, 32'h7FFF_FFFF);
        settle();

        clock_ms = $urandom;

        // Typical calibration.
        load_cal(12'd500, 12'd3500, 12'd300, 12'd3800, 12'd200, 12'd3900, 12'd100, 12'd100);
        run_phase(90, 1'b0);
        // Full spans; upper bits of the 10-bit registers are dropped: limit 1023, activation 0.
        load_cal(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'hFFF, 12'hC00);
        run_phase(90, 1'b0);
        // Zero and reversed spans; limit 0 after the dropped bit, top activation.
        load_cal(12'd2000, 12'd2000, 12'd3000, 12'd1000, 12'd4095, 12'd0, 12'h400, 12'd1000);
        run_phase(80, 1'b0);
        // One-count spans at both ends of the range.
        load_cal(12'd1000, 12'd1001, 12'd4094, 12'd4095, 12'd0, 12'd1, 12'd1000, 12'd500);
        run_phase(80, 1'b0);
        // Anything at all.
        load_cal(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                 CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        run_phase(100, 1'b0);
        // Back-pressure: hold the receiver off while words keep coming.
        load_cal(12'd400, 12'd3600, 12'd250, 12'd3700, 12'd150, 12'd4000, 12'd50, 12'd300);
        run_phase(100, 1'b1);

        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[pedal_plausibility_monitor] OK");
        else
            $display("[pedal_plausibility_monitor] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ppm_pkg.sv
hw/rtl/pedal_plausibility_monitor.sv
sim/ppm_checker.sv
sim/pedal_plausibility_monitor_tb.sv
